@@ rtl/core/i2cra_pkg.sv @@
// Package: shared types and codes for the I2C register access master.
`timescale 1ns / 1ps
package i2cra_pkg;

  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_WR_REG   = 2'd1;
  localparam logic [1:0] FUNC_RD_BYTE  = 2'd2;
  localparam logic [1:0] FUNC_RD_WORD  = 2'd3;

  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_START = 3'd1,
    ST_LO    = 3'd2,
    ST_HI    = 3'd3,
    ST_STOP  = 3'd4
  } step_t;

  typedef enum logic [2:0] {
    SL_DEVW = 3'd0,
    SL_REG  = 3'd1,
    SL_DATA = 3'd2,
    SL_DEVR = 3'd3,
    SL_RXH  = 3'd4,
    SL_RXL  = 3'd5
  } slot_t;

  typedef struct packed {
    logic       is_cmd;
    logic [1:0] func;
    logic [7:0] slave_addr;
    logic [7:0] reg_index;
    logic [7:0] wr_data;
    logic       sda_in;
  } item_t;

endpackage

@@ rtl/core/i2cra_front.sv @@
// Front end: accept input words, classify them and queue them for the sequencer.
`timescale 1ns / 1ps
module i2cra_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_func,
  input  logic [7:0]     in_slave_addr,
  input  logic [7:0]     in_reg_index,
  input  logic [7:0]     in_wr_data,
  input  logic           in_sda_in,
  output logic           q_valid,
  output i2cra_pkg::item_t q_item,
  input  logic           q_pop
);
  import i2cra_pkg::*;

  item_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               push;
  logic               pop;
  item_t              new_item;

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count_r != '0);
  assign q_valid  = (count_r != '0);
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    new_item.is_cmd     = (in_func != FUNC_TICK);
    new_item.func       = in_func;
    new_item.slave_addr = in_slave_addr;
    new_item.reg_index  = in_reg_index;
    new_item.wr_data    = in_wr_data;
    new_item.sda_in     = in_sda_in;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty queue with unequal pointers");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not lower count");
`endif

endmodule

@@ rtl/core/i2cra_seq.sv @@
// Back end: I2C bus sequencer and registered result word.
`timescale 1ns / 1ps
module i2cra_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             q_valid,
  input  i2cra_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_scl,
  output logic             out_sda_release,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [15:0]      out_rd_data,
  output logic             out_acked
);
  import i2cra_pkg::*;

  logic [15:0] phase_ticks_r;
  step_t       step_r, step_nxt;
  slot_t       slot_r, slot_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [15:0] read_word_r, read_word_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        ack_seen_r, ack_seen_nxt;
  logic        done_nxt;

  logic        out_valid_r;
  logic        scl_r, sda_r, busy_r, done_r, acked_r;
  logic [15:0] rd_data_r;

  logic [15:0] limit;
  logic        half_end;
  logic        tx_slot;
  logic [7:0]  rx_byte;
  logic        scl_nxt, sda_nxt, level;
  logic        take;

  assign take  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = take;

  assign limit    = (phase_ticks_r == '0) ? 16'd1 : phase_ticks_r;
  assign half_end = ({1'b0, tick_count_r} + 17'd1) >= {1'b0, limit};
  assign tx_slot  = (slot_r == SL_DEVW) || (slot_r == SL_REG) ||
                    (slot_r == SL_DATA) || (slot_r == SL_DEVR);
  assign rx_byte  = {shift_byte_r[6:0], q_item.sda_in};

  always_comb begin
    step_nxt       = step_r;
    slot_nxt       = slot_r;
    bit_count_nxt  = bit_count_r;
    shift_byte_nxt = shift_byte_r;
    read_word_nxt  = read_word_r;
    tick_count_nxt = tick_count_r;
    func_nxt       = func_r;
    dev_nxt        = dev_r;
    reg_nxt        = reg_r;
    data_nxt       = data_r;
    ack_seen_nxt   = ack_seen_r;
    done_nxt       = 1'b0;
    if (step_r == ST_IDLE) begin
      if (q_item.is_cmd) begin
        func_nxt       = q_item.func;
        dev_nxt        = q_item.slave_addr;
        reg_nxt        = q_item.reg_index;
        data_nxt       = q_item.wr_data;
        ack_seen_nxt   = 1'b1;
        if (q_item.func != FUNC_WR_REG) begin
          read_word_nxt = '0;
        end
        slot_nxt       = SL_DEVW;
        shift_byte_nxt = q_item.slave_addr;
        step_nxt       = ST_START;
        bit_count_nxt  = 4'd1;
        tick_count_nxt = '0;
      end
    end else if (half_end) begin
      tick_count_nxt = '0;
      unique case (step_r)
        ST_START: begin
          if (bit_count_r < 4'd2) begin
            bit_count_nxt = bit_count_r + 4'd1;
          end else begin
            step_nxt      = ST_LO;
            bit_count_nxt = '0;
          end
        end
        ST_LO: begin
          step_nxt = ST_HI;
        end
        ST_HI: begin
          if (tx_slot) begin
            if (bit_count_r < 4'd8) begin
              shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
            end else if (q_item.sda_in) begin
              ack_seen_nxt = 1'b0;
            end
          end else if (bit_count_r < 4'd8) begin
            shift_byte_nxt = rx_byte;
            if (bit_count_r == 4'd7) begin
              read_word_nxt = {read_word_r[7:0], rx_byte};
            end
          end
          if (bit_count_r < 4'd8) begin
            bit_count_nxt = bit_count_r + 4'd1;
            step_nxt      = ST_LO;
          end else begin
            bit_count_nxt = '0;
            unique case (slot_r)
              SL_DEVW: begin
                slot_nxt       = SL_REG;
                shift_byte_nxt = reg_r;
                step_nxt       = ST_LO;
              end
              SL_REG: begin
                if (func_r == FUNC_WR_REG) begin
                  slot_nxt       = SL_DATA;
                  shift_byte_nxt = data_r;
                  step_nxt       = ST_LO;
                end else begin
                  slot_nxt       = SL_DEVR;
                  shift_byte_nxt = dev_r + 8'd1;
                  step_nxt       = ST_START;
                end
              end
              SL_DEVR: begin
                slot_nxt       = SL_RXH;
                shift_byte_nxt = '0;
                step_nxt       = ST_LO;
              end
              SL_RXH: begin
                if (func_r == FUNC_RD_WORD) begin
                  slot_nxt       = SL_RXL;
                  shift_byte_nxt = '0;
                  step_nxt       = ST_LO;
                end else begin
                  step_nxt = ST_STOP;
                end
              end
              default: begin
                step_nxt = ST_STOP;
              end
            endcase
          end
        end
        ST_STOP: begin
          if (bit_count_r < 4'd2) begin
            bit_count_nxt = bit_count_r + 4'd1;
          end else begin
            step_nxt      = ST_IDLE;
            slot_nxt      = SL_DEVW;
            bit_count_nxt = '0;
            done_nxt      = 1'b1;
          end
        end
        default: begin
          step_nxt = ST_IDLE;
        end
      endcase
    end else begin
      tick_count_nxt = tick_count_r + 16'd1;
    end
  end

  always_comb begin
    if ((slot_nxt == SL_DEVW) || (slot_nxt == SL_REG) ||
        (slot_nxt == SL_DATA) || (slot_nxt == SL_DEVR)) begin
      level = (bit_count_nxt < 4'd8) ? shift_byte_nxt[7] : 1'b1;
    end else if (bit_count_nxt < 4'd8) begin
      level = 1'b1;
    end else begin
      level = !((slot_nxt == SL_RXH) && (func_nxt == FUNC_RD_WORD));
    end
    unique case (step_nxt)
      ST_START: begin
        scl_nxt = (bit_count_nxt != 4'd0);
        sda_nxt = (bit_count_nxt != 4'd2);
      end
      ST_LO: begin
        scl_nxt = 1'b0;
        sda_nxt = level;
      end
      ST_HI: begin
        scl_nxt = 1'b1;
        sda_nxt = level;
      end
      ST_STOP: begin
        scl_nxt = (bit_count_nxt != 4'd0);
        sda_nxt = (bit_count_nxt == 4'd2);
      end
      default: begin
        scl_nxt = 1'b1;
        sda_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= 16'd1;
    end else if (cfg_wr_en) begin
      phase_ticks_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ST_IDLE;
      slot_r       <= SL_DEVW;
      bit_count_r  <= '0;
      shift_byte_r <= '0;
      read_word_r  <= '0;
      tick_count_r <= '0;
      func_r       <= FUNC_TICK;
      dev_r        <= '0;
      reg_r        <= '0;
      data_r       <= '0;
      ack_seen_r   <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        step_r       <= step_nxt;
        slot_r       <= slot_nxt;
        bit_count_r  <= bit_count_nxt;
        shift_byte_r <= shift_byte_nxt;
        read_word_r  <= read_word_nxt;
        tick_count_r <= tick_count_nxt;
        func_r       <= func_nxt;
        dev_r        <= dev_nxt;
        reg_r        <= reg_nxt;
        data_r       <= data_nxt;
        ack_seen_r   <= ack_seen_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      busy_r    <= (step_nxt != ST_IDLE);
      done_r    <= done_nxt;
      rd_data_r <= read_word_nxt;
      acked_r   <= ack_seen_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl         = scl_r;
  assign out_sda_release = sda_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_rd_data     = rd_data_r;
  assign out_acked       = acked_r;

`ifndef ASSERT_OFF
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_IDLE) |-> ((bit_count_r == 4'd0) && (tick_count_r == '0)))
    else $error("idle with live counters");
  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= 4'd8)
    else $error("bit count beyond ack slot");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> !busy_r)
    else $error("done while busy");
  a_done_from_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (take && done_nxt) |-> (step_r == ST_STOP))
    else $error("done outside stop");
`endif

endmodule

@@ rtl/core/i2c_register_access_master_core.sv @@
// Top level: I2C register access master with queued tick words.
// A tick word is taken from the queue and its result word is registered in the output register.
// Throughput: one tick word per cycle unless out_stall holds; a step spans phase_ticks words.
// A two-word queue parts input from the sequencer; one output register holds results.
// Reset (synchronous, rst_n low) empties the queue and idles the sequencer, phase_ticks = 1.
`timescale 1ns / 1ps
module i2c_register_access_master_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_slave_addr,
  input  logic [7:0]  in_reg_index,
  input  logic [7:0]  in_wr_data,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl,
  output logic        out_sda_release,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [15:0] out_rd_data,
  output logic        out_acked
);
  import i2cra_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  i2cra_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_slave_addr (in_slave_addr),
    .in_reg_index  (in_reg_index),
    .in_wr_data    (in_wr_data),
    .in_sda_in     (in_sda_in),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  i2cra_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_scl         (out_scl),
    .out_sda_release (out_sda_release),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_rd_data     (out_rd_data),
    .out_acked       (out_acked)
  );

endmodule
